// ----- src/ced_pkg.sv -----
// Shared types and codes for the C escape sequence decoder.
// No dependencies; imported by ced_decode and c_escape_sequence_decoder.
package ced_pkg;

    // Parse modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_OCT  = 2'd3;

    // Most words one character can produce
    localparam int unsigned MAX_RES = 3;

    // Character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] value;
        logic [1:0] count;
    } t_state;

    typedef struct packed {
        logic       eos;
        logic       has_char;
        logic [7:0] ch;
    } t_result;

    typedef struct packed {
        logic [1:0]            num;
        t_result [MAX_RES-1:0] res;
    } t_dec_out;

endpackage

// ----- src/ced_decode.sv -----
// Combinational decode of one character against the current parse state.
// Depends on ced_pkg for state, result and mode definitions.
module ced_decode (
    input  ced_pkg::t_state   i_state,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output ced_pkg::t_state   o_state,
    output ced_pkg::t_dec_out o_out
);
    import ced_pkg::*;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        // bit 4 set means a valid digit
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c[7:3] == 5'b00110;
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= 8'd32 && c < 8'd127) || (c >= 8'd8 && c < 8'd11);
    endfunction

    // Candidate words in order: two escape prefix words, one plain word,
    // two flush words.
    logic [7:0] e_ch [5];
    logic [4:0] e_v;
    t_state     st;
    logic       do_plain;
    logic [4:0] h;
    logic [8:0] nv;
    logic [1:0] nk;
    logic [1:0] n;
    t_dec_out   res;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            e_ch[i] = 8'd0;
        end
        e_v      = '0;
        st       = i_state;
        do_plain = 1'b0;
        h        = hex_val(i_ch);
        nv       = 9'd0;
        nk       = 2'd0;

        unique case (i_state.mode)
            MODE_IDLE: do_plain = 1'b1;
            MODE_ESC: begin
                st = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
                e_v[0] = 1'b1;
                case (i_ch)
                    8'h6E:   e_ch[0] = 8'd10;   // n
                    8'h74:   e_ch[0] = 8'd9;    // t
                    8'h76:   e_ch[0] = 8'd11;   // v
                    8'h62:   e_ch[0] = 8'd8;    // b
                    8'h72:   e_ch[0] = 8'd13;   // r
                    8'h5C:   e_ch[0] = 8'd92;
                    8'h27:   e_ch[0] = 8'd39;
                    8'h22:   e_ch[0] = 8'd34;
                    CH_X: begin
                        e_v[0]  = 1'b0;
                        st.mode = MODE_HEX;
                    end
                    default: begin
                        if (is_oct(i_ch)) begin
                            e_v[0]   = 1'b0;
                            st.mode  = MODE_OCT;
                            st.value = {6'd0, i_ch[2:0]};
                            st.count = 2'd1;
                        end else begin
                            e_ch[0]  = CH_BSLASH;
                            do_plain = 1'b1;
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                if (h[4]) begin
                    nv = {i_state.value[4:0], h[3:0]};
                    nk = i_state.count + 2'd1;
                    if (nk >= 2'd2) begin
                        e_v[0]  = 1'b1;
                        e_ch[0] = nv[7:0];
                        st      = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
                    end else begin
                        st.value = nv;
                        st.count = nk;
                    end
                end else begin
                    e_v[0] = 1'b1;
                    if (i_state.count == 2'd0) begin
                        e_ch[0] = CH_BSLASH;
                        e_v[1]  = 1'b1;
                        e_ch[1] = CH_X;
                    end else begin
                        e_ch[0] = i_state.value[7:0];
                    end
                    st       = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
                    do_plain = 1'b1;
                end
            end
            MODE_OCT: begin
                if (is_oct(i_ch)) begin
                    nv = {i_state.value[5:0], i_ch[2:0]};
                    nk = i_state.count + 2'd1;
                    if (nk == 2'd3) begin
                        e_v[0]  = 1'b1;
                        e_ch[0] = nv[7:0];
                        st      = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
                    end else begin
                        st.value = nv;
                        st.count = nk;
                    end
                end else begin
                    e_v[0]   = 1'b1;
                    e_ch[0]  = i_state.value[7:0];
                    st       = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
                    do_plain = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        // Plain character handling
        if (do_plain) begin
            if (i_ch == CH_BSLASH) begin
                st.mode = MODE_ESC;
            end else if (is_print(i_ch)) begin
                e_v[2]  = 1'b1;
                e_ch[2] = i_ch;
            end
        end

        // End of string: flush whatever escape is pending
        if (i_last) begin
            unique case (st.mode)
                MODE_IDLE: ;
                MODE_ESC: begin
                    e_v[3]  = 1'b1;
                    e_ch[3] = CH_BSLASH;
                end
                MODE_HEX: begin
                    e_v[3] = 1'b1;
                    if (st.count == 2'd0) begin
                        e_ch[3] = CH_BSLASH;
                        e_v[4]  = 1'b1;
                        e_ch[4] = CH_X;
                    end else begin
                        e_ch[3] = st.value[7:0];
                    end
                end
                MODE_OCT: begin
                    e_v[3]  = 1'b1;
                    e_ch[3] = st.value[7:0];
                end
                default: ;
            endcase
            st = '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
        end
    end

    // Pack candidates into at most three words; on the last character, tag the final one
    always_comb begin
        res = '0;
        n   = 2'd0;
        for (int i = 0; i < 5; i++) begin
            if (e_v[i] && n != 2'd3) begin
                res.res[n].ch       = e_ch[i];
                res.res[n].has_char = 1'b1;
                n                   = n + 2'd1;
            end
        end
        if (i_last) begin
            if (n == 2'd0) begin
                res.res[0].eos = 1'b1;
                n              = 2'd1;
            end else begin
                res.res[n - 2'd1].eos = 1'b1;
            end
        end
        res.num = n;
    end

    assign o_state = st;
    assign o_out   = res;

endmodule

// ----- src/c_escape_sequence_decoder.sv -----
// Result words are written into a registered four-entry result queue before the output.
// Throughput: one character per cycle while each produces at most one word and the output
// accepts every word; words leave at one per cycle while i_m_tready is high, so bursts of
// two or three words from one character are set by the output side draining the queue.
// Reset (i_rst_n low, synchronous): parse state returns to idle, result queue empties.
// Depends on ced_pkg and ced_decode.
module c_escape_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input character stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic       i_s_tlast,   // last character of the string
    // decoded stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_ch
    output logic       o_m_tuser,   // [0] has_char
    output logic       o_m_tlast    // end_of_string
);
    import ced_pkg::*;

    localparam int unsigned QDEPTH = 4;

    // parse state
    t_state   r_state;
    t_state   n_state;
    t_dec_out dec;

    // result queue: four entries, up to three pushed per character
    t_result    r_q [QDEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_acc;
    logic       out_acc;

    ced_decode u_dec (
        .i_state (r_state),
        .i_ch    (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_state (n_state),
        .o_out   (dec)
    );

    // room for a worst-case burst of three words
    assign o_s_tready = (r_cnt <= 3'd1);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = o_m_tvalid && i_m_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc) n_cnt = n_cnt + {1'b0, dec.num};
        if (out_acc) n_cnt = n_cnt - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '{mode: MODE_IDLE, value: 9'd0, count: 2'd0};
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 3'd0;
        end else begin
            if (in_acc) begin
                r_state  <= n_state;
                r_wr_ptr <= r_wr_ptr + dec.num;
            end
            if (out_acc) r_rd_ptr <= r_rd_ptr + 2'd1;
            r_cnt <= n_cnt;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int j = 0; j < MAX_RES; j++) begin
                if (2'(j) < dec.num) r_q[r_wr_ptr + 2'(j)] <= dec.res[j];
            end
        end
    end

    assign o_m_tvalid = (r_cnt != 3'd0);
    assign o_m_tdata  = r_q[r_rd_ptr].ch;
    assign o_m_tuser  = r_q[r_rd_ptr].has_char;
    assign o_m_tlast  = r_q[r_rd_ptr].eos;

endmodule
